### rtl/core/tga_pkg.sv
// shared types and constants of the tga truecolour stream decoder
package tga_pkg;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_SHORT_HEADER = 3'd1;
  localparam logic [2:0] ERR_COMPRESSED   = 3'd2;
  localparam logic [2:0] ERR_COLOUR_MAP   = 3'd3;
  localparam logic [2:0] ERR_BAD_DEPTH    = 3'd4;
  localparam logic [2:0] ERR_SHORT_ID     = 3'd5;
  localparam logic [2:0] ERR_SHORT_PIXELS = 3'd6;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_ID     = 4'b0010,
    PH_PIXELS = 4'b0100,
    PH_WAIT   = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    OP_HEADER = 2'd0,
    OP_ERROR  = 2'd1,
    OP_COLOUR = 2'd2,
    OP_PIXEL  = 2'd3
  } op_t;

  localparam logic [4:0] HDR_ID_LEN  = 5'd0;
  localparam logic [4:0] HDR_CMAP    = 5'd1;
  localparam logic [4:0] HDR_TYPE    = 5'd2;
  localparam logic [4:0] HDR_W_LO    = 5'd12;
  localparam logic [4:0] HDR_W_HI    = 5'd13;
  localparam logic [4:0] HDR_H_LO    = 5'd14;
  localparam logic [4:0] HDR_H_HI    = 5'd15;
  localparam logic [4:0] HDR_DEPTH   = 5'd16;
  localparam logic [4:0] HDR_LAST    = 5'd17;

  localparam logic [7:0] TYPE_TRUECOLOUR = 8'd2;
  localparam logic [7:0] DEPTH_24        = 8'd24;
  localparam logic [7:0] DEPTH_32        = 8'd32;
  localparam logic [7:0] ALPHA_OPAQUE    = 8'hff;

  localparam logic [1:0] SLOT_RED   = 2'd2;
  localparam logic [1:0] SLOT_ALPHA = 2'd3;

  typedef struct packed {
    op_t         op;
    logic [7:0]  data;
    logic [1:0]  slot;
    logic        last;
    logic [2:0]  err;
    logic [15:0] width;
    logic [15:0] height;
    logic        depth32;
  } cmd_t;

endpackage

### rtl/core/tga_if.sv
// request channel interfaces for the byte input and the result output
interface tga_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface tga_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic        alpha_used;
  logic [2:0]  error_code;
  logic        last;

  modport source (output valid, output kind, output red, output green, output blue,
                  output alpha, output image_width, output image_height,
                  output alpha_used, output error_code, output last, input ready);
  modport sink   (input valid, input kind, input red, input green, input blue,
                  input alpha, input image_width, input image_height,
                  input alpha_used, input error_code, input last, output ready);
endinterface

### rtl/core/tga_front.sv
// front end: header parser and byte classifier, issues commands to the queue
module tga_front (
  input  logic          clk,
  input  logic          rst_n,
  tga_in_if.sink        in_chan,
  output logic          push,
  output tga_pkg::cmd_t cmd,
  input  logic          q_full
);

  tga_pkg::phase_t phase_r, phase_nxt;
  logic [4:0]  hcount_r, hcount_nxt;
  logic [7:0]  id_left_r, id_left_nxt;
  logic [7:0]  image_type_r, image_type_nxt;
  logic [7:0]  cmap_r, cmap_nxt;
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic        depth32_r, depth32_nxt;
  logic        depth_ok_r, depth_ok_nxt;
  logic [15:0] col_r, col_nxt;
  logic [15:0] row_r, row_nxt;
  logic [1:0]  bip_r, bip_nxt;

  logic        accept;
  logic        do_header;
  logic        do_pixel;
  logic        empty_img;
  logic        col_wrap;
  logic        row_wrap;
  logic [7:0]  b;

  assign in_chan.ready = !q_full;
  assign accept = in_chan.valid && in_chan.ready;
  assign b = in_chan.data_byte;
  assign empty_img = (width_r == 16'd0) || (height_r == 16'd0);
  assign col_wrap = (col_r + 16'd1) == width_r;
  assign row_wrap = (row_r + 16'd1) == height_r;

  always_comb begin
    phase_nxt      = phase_r;
    hcount_nxt     = hcount_r;
    id_left_nxt    = id_left_r;
    image_type_nxt = image_type_r;
    cmap_nxt       = cmap_r;
    width_nxt      = width_r;
    height_nxt     = height_r;
    depth32_nxt    = depth32_r;
    depth_ok_nxt   = depth_ok_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    bip_nxt        = bip_r;
    do_header      = 1'b0;
    do_pixel       = 1'b0;
    push           = 1'b0;
    cmd            = '0;
    cmd.width      = width_r;
    cmd.height     = height_r;
    cmd.depth32    = depth32_r;

    if (accept && in_chan.end_of_stream) begin
      unique case (phase_r)
        tga_pkg::PH_HEADER: begin
          push    = 1'b1;
          cmd.op  = tga_pkg::OP_ERROR;
          cmd.err = tga_pkg::ERR_SHORT_HEADER;
        end
        tga_pkg::PH_ID: begin
          push    = 1'b1;
          cmd.op  = tga_pkg::OP_ERROR;
          cmd.err = tga_pkg::ERR_SHORT_ID;
        end
        tga_pkg::PH_PIXELS: begin
          push    = 1'b1;
          cmd.op  = tga_pkg::OP_ERROR;
          cmd.err = tga_pkg::ERR_SHORT_PIXELS;
        end
        default: ;
      endcase
      phase_nxt  = tga_pkg::PH_HEADER;
      hcount_nxt = '0;
      bip_nxt    = '0;
      col_nxt    = '0;
      row_nxt    = '0;
    end else if (accept) begin
      unique case (phase_r)
        tga_pkg::PH_HEADER: begin
          case (hcount_r)
            tga_pkg::HDR_ID_LEN: id_left_nxt    = b;
            tga_pkg::HDR_CMAP:   cmap_nxt       = b;
            tga_pkg::HDR_TYPE:   image_type_nxt = b;
            tga_pkg::HDR_W_LO:   width_nxt      = {width_r[15:8], b};
            tga_pkg::HDR_W_HI:   width_nxt      = {b, width_r[7:0]};
            tga_pkg::HDR_H_LO:   height_nxt     = {height_r[15:8], b};
            tga_pkg::HDR_H_HI:   height_nxt     = {b, height_r[7:0]};
            tga_pkg::HDR_DEPTH: begin
              depth32_nxt  = (b == tga_pkg::DEPTH_32);
              depth_ok_nxt = (b == tga_pkg::DEPTH_24) || (b == tga_pkg::DEPTH_32);
            end
            default: ;
          endcase
          if (hcount_r != tga_pkg::HDR_LAST) begin
            hcount_nxt = hcount_r + 5'd1;
          end else begin
            hcount_nxt = '0;
            if (image_type_r != tga_pkg::TYPE_TRUECOLOUR) begin
              phase_nxt = tga_pkg::PH_WAIT;
              push      = 1'b1;
              cmd.op    = tga_pkg::OP_ERROR;
              cmd.err   = tga_pkg::ERR_COMPRESSED;
            end else if (cmap_r != 8'd0) begin
              phase_nxt = tga_pkg::PH_WAIT;
              push      = 1'b1;
              cmd.op    = tga_pkg::OP_ERROR;
              cmd.err   = tga_pkg::ERR_COLOUR_MAP;
            end else if (!depth_ok_r) begin
              phase_nxt = tga_pkg::PH_WAIT;
              push      = 1'b1;
              cmd.op    = tga_pkg::OP_ERROR;
              cmd.err   = tga_pkg::ERR_BAD_DEPTH;
            end else if (id_left_r != 8'd0) begin
              phase_nxt = tga_pkg::PH_ID;
            end else begin
              do_header = 1'b1;
            end
          end
        end
        tga_pkg::PH_ID: begin
          id_left_nxt = id_left_r - 8'd1;
          if (id_left_r == 8'd1) begin
            do_header = 1'b1;
          end
        end
        tga_pkg::PH_PIXELS: begin
          if (bip_r == tga_pkg::SLOT_ALPHA) begin
            do_pixel = 1'b1;
          end else if (bip_r == tga_pkg::SLOT_RED && !depth32_r) begin
            do_pixel = 1'b1;
          end else begin
            push     = 1'b1;
            cmd.op   = tga_pkg::OP_COLOUR;
            cmd.data = b;
            cmd.slot = bip_r;
            bip_nxt  = bip_r + 2'd1;
          end
        end
        tga_pkg::PH_WAIT: ;
        default: ;
      endcase
    end

    if (do_header) begin
      push      = 1'b1;
      cmd.op    = tga_pkg::OP_HEADER;
      cmd.last  = empty_img;
      phase_nxt = empty_img ? tga_pkg::PH_WAIT : tga_pkg::PH_PIXELS;
    end

    if (do_pixel) begin
      push     = 1'b1;
      cmd.op   = tga_pkg::OP_PIXEL;
      cmd.data = b;
      cmd.slot = bip_r;
      bip_nxt  = '0;
      if (col_wrap) begin
        col_nxt = '0;
        if (row_wrap) begin
          cmd.last  = 1'b1;
          phase_nxt = tga_pkg::PH_WAIT;
        end else begin
          row_nxt = row_r + 16'd1;
        end
      end else begin
        col_nxt = col_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= tga_pkg::PH_HEADER;
      hcount_r <= '0;
      bip_r    <= '0;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      hcount_r <= hcount_nxt;
      bip_r    <= bip_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_left_r    <= id_left_nxt;
    image_type_r <= image_type_nxt;
    cmap_r       <= cmap_nxt;
    width_r      <= width_nxt;
    height_r     <= height_nxt;
    depth32_r    <= depth32_nxt;
    depth_ok_r   <= depth_ok_nxt;
  end

endmodule

### rtl/core/tga_cmd_fifo.sv
// command queue between the front end and the back end
module tga_cmd_fifo #(
  parameter int Depth = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  tga_pkg::cmd_t                push_cmd,
  input  logic                         pop,
  output tga_pkg::cmd_t                head,
  output logic                         full,
  output logic                         empty,
  output logic [$clog2(Depth+1)-1:0]   level
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  tga_pkg::cmd_t   mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  assign full  = count_r == CntW'(Depth);
  assign empty = count_r == '0;
  assign level = count_r;
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### rtl/core/tga_back.sv
// back end: pixel assembly, opacity tracking and the result register
module tga_back (
  input  logic          clk,
  input  logic          rst_n,
  input  tga_pkg::cmd_t head,
  input  logic          q_empty,
  output logic          pop,
  tga_out_if.source     out_chan
);

  logic [7:0]  held_r [3];
  logic [7:0]  held_nxt [3];
  logic        opaque_r, opaque_nxt;
  logic        valid_r, valid_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  red_r, red_nxt;
  logic [7:0]  green_r, green_nxt;
  logic [7:0]  blue_r, blue_nxt;
  logic [7:0]  alpha_r, alpha_nxt;
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic        used_r, used_nxt;
  logic [2:0]  err_r, err_nxt;
  logic        last_r, last_nxt;

  logic        emit;
  logic [7:0]  pix_red;
  logic [7:0]  pix_alpha;
  logic        pix_opaque;

  assign pop = !q_empty && (!valid_r || out_chan.ready);

  always_comb begin
    if (head.slot == tga_pkg::SLOT_RED) begin
      pix_red   = head.data;
      pix_alpha = tga_pkg::ALPHA_OPAQUE;
    end else begin
      pix_red   = held_r[2];
      pix_alpha = head.data;
    end
    pix_opaque = opaque_r && (pix_alpha == tga_pkg::ALPHA_OPAQUE);
  end

  always_comb begin
    held_nxt   = held_r;
    opaque_nxt = opaque_r;
    emit       = 1'b0;
    kind_nxt   = kind_r;
    red_nxt    = red_r;
    green_nxt  = green_r;
    blue_nxt   = blue_r;
    alpha_nxt  = alpha_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    used_nxt   = used_r;
    err_nxt    = err_r;
    last_nxt   = last_r;

    if (pop) begin
      unique case (head.op)
        tga_pkg::OP_COLOUR: begin
          case (head.slot)
            2'd0:    held_nxt[0] = head.data;
            2'd1:    held_nxt[1] = head.data;
            2'd2:    held_nxt[2] = head.data;
            default: ;
          endcase
        end
        tga_pkg::OP_HEADER: begin
          emit       = 1'b1;
          opaque_nxt = 1'b1;
          kind_nxt   = tga_pkg::KIND_HEADER;
          red_nxt    = '0;
          green_nxt  = '0;
          blue_nxt   = '0;
          alpha_nxt  = '0;
          width_nxt  = head.width;
          height_nxt = head.height;
          used_nxt   = head.depth32;
          err_nxt    = tga_pkg::ERR_NONE;
          last_nxt   = head.last;
        end
        tga_pkg::OP_ERROR: begin
          emit       = 1'b1;
          kind_nxt   = tga_pkg::KIND_ERROR;
          red_nxt    = '0;
          green_nxt  = '0;
          blue_nxt   = '0;
          alpha_nxt  = '0;
          width_nxt  = '0;
          height_nxt = '0;
          used_nxt   = 1'b0;
          err_nxt    = head.err;
          last_nxt   = 1'b0;
        end
        tga_pkg::OP_PIXEL: begin
          emit       = 1'b1;
          opaque_nxt = pix_opaque;
          kind_nxt   = tga_pkg::KIND_PIXEL;
          red_nxt    = pix_red;
          green_nxt  = held_r[1];
          blue_nxt   = held_r[0];
          alpha_nxt  = pix_alpha;
          width_nxt  = head.width;
          height_nxt = head.height;
          used_nxt   = head.depth32 && !pix_opaque;
          err_nxt    = tga_pkg::ERR_NONE;
          last_nxt   = head.last;
        end
        default: ;
      endcase
    end

    valid_nxt = valid_r;
    if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end
    if (emit) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      opaque_r <= 1'b1;
    end else begin
      valid_r  <= valid_nxt;
      opaque_r <= opaque_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r   <= held_nxt;
    kind_r   <= kind_nxt;
    red_r    <= red_nxt;
    green_r  <= green_nxt;
    blue_r   <= blue_nxt;
    alpha_r  <= alpha_nxt;
    width_r  <= width_nxt;
    height_r <= height_nxt;
    used_r   <= used_nxt;
    err_r    <= err_nxt;
    last_r   <= last_nxt;
  end

  assign out_chan.valid        = valid_r;
  assign out_chan.kind         = kind_r;
  assign out_chan.red          = red_r;
  assign out_chan.green        = green_r;
  assign out_chan.blue         = blue_r;
  assign out_chan.alpha        = alpha_r;
  assign out_chan.image_width  = width_r;
  assign out_chan.image_height = height_r;
  assign out_chan.alpha_used   = used_r;
  assign out_chan.error_code   = err_r;
  assign out_chan.last         = last_r;

endmodule

### rtl/core/tga_truecolor_stream_decoder.sv
// top level of the uncompressed truecolour tga stream decoder
// Takes one file byte per request and sustains one byte per clock cycle while
// the queue is not full. The front end parses the 18-byte header, skips the
// ID field and sorts pixel bytes; every byte that yields a result, and every
// colour byte, goes as a command into a QueueDepth-entry queue. The back end
// drains one command per cycle, unless a held result is not taken, into a
// single result register; a result passes a queue entry, then that register.
// Input ready drops only while the queue is full, that is while the output
// side has stalled long enough to fill it; no clearing pass follows reset.
module tga_truecolor_stream_decoder #(
  parameter int QueueDepth = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  tga_in_if.sink     in_chan,
  tga_out_if.source  out_chan
);

  localparam int LevelW = $clog2(QueueDepth + 1);

  tga_pkg::cmd_t     push_cmd;
  tga_pkg::cmd_t     head;
  logic              push;
  logic              pop;
  logic              q_full;
  logic              q_empty;
  logic [LevelW-1:0] q_level;

  tga_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .push    (push),
    .cmd     (push_cmd),
    .q_full  (q_full)
  );

  tga_cmd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty),
    .level    (q_level)
  );

  tga_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_empty  (q_empty),
    .pop      (pop),
    .out_chan (out_chan)
  );

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_level <= LevelW'(QueueDepth))
    else $error("command queue over capacity");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_level != '0)
    else $error("pop from empty command queue");

  a_error_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.kind == tga_pkg::KIND_ERROR) |->
      (out_chan.error_code != tga_pkg::ERR_NONE && !out_chan.last && !out_chan.alpha_used))
    else $error("malformed error result");

  a_good_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.kind != tga_pkg::KIND_ERROR) |->
      out_chan.error_code == tga_pkg::ERR_NONE)
    else $error("error code on a non-error result");

endmodule

### dv/tga_truecolor_stream_decoder_tb.sv
// self-checking testbench of the tga truecolour stream decoder
module tga_truecolor_stream_decoder_tb;
  import tga_pkg::*;

  localparam int StallLimit  = 2000;
  localparam int RandomItems = 150;
  localparam int DrainCycles = 16;
  localparam int IdlePct     = 35;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        alpha_used;
    logic [2:0]  error_code;
    logic        last;
  } decode_result_t;

  class decode_scoreboard;
    phase_t         ph;
    logic [4:0]     hdr_count;
    logic [7:0]     id_left;
    logic [7:0]     img_type;
    logic [7:0]     cmap_type;
    logic [15:0]    width;
    logic [15:0]    height;
    logic           depth32;
    logic           depth_ok;
    logic [15:0]    col;
    logic [15:0]    row;
    logic [1:0]     pix_byte;
    logic [7:0]     held [3];
    logic           opaque;
    decode_result_t expected[$];
    int             mismatches;

    function new();
      rearm();
      mismatches = 0;
    endfunction

    function void rearm();
      ph        = PH_HEADER;
      hdr_count = '0;
      id_left   = '0;
      img_type  = '0;
      cmap_type = '0;
      width     = '0;
      height    = '0;
      depth32   = 1'b0;
      depth_ok  = 1'b0;
      col       = '0;
      row       = '0;
      pix_byte  = '0;
      held      = '{default: '0};
      opaque    = 1'b1;
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function decode_result_t error_result(logic [2:0] code);
      decode_result_t r;
      r = '0;
      r.kind = KIND_ERROR;
      r.error_code = code;
      return r;
    endfunction

    function decode_result_t header_result();
      decode_result_t r;
      logic empty;
      empty = (width == 16'd0) || (height == 16'd0);
      r = '0;
      r.kind = KIND_HEADER;
      r.image_width = width;
      r.image_height = height;
      r.alpha_used = depth32;
      r.last = empty;
      ph = empty ? PH_WAIT : PH_PIXELS;
      return r;
    endfunction

    function decode_result_t pixel_result(logic [7:0] a);
      decode_result_t r;
      logic done;
      done = 1'b0;
      if (a != ALPHA_OPAQUE) opaque = 1'b0;
      r = '0;
      r.kind = KIND_PIXEL;
      r.red = held[2];
      r.green = held[1];
      r.blue = held[0];
      r.alpha = a;
      r.image_width = width;
      r.image_height = height;
      r.alpha_used = depth32 && !opaque;
      pix_byte = '0;
      if (col + 16'd1 == width) begin
        col = '0;
        if (row + 16'd1 == height) done = 1'b1;
        else row = row + 16'd1;
      end else begin
        col = col + 16'd1;
      end
      if (done) ph = PH_WAIT;
      r.last = done;
      return r;
    endfunction

    function void note_request(logic [7:0] b, logic eos);
      decode_result_t r;
      bit hit;
      r = '0;
      hit = 1'b0;
      if (eos) begin
        hit = 1'b1;
        case (ph)
          PH_HEADER: r = error_result(ERR_SHORT_HEADER);
          PH_ID:     r = error_result(ERR_SHORT_ID);
          PH_PIXELS: r = error_result(ERR_SHORT_PIXELS);
          default:   hit = 1'b0;
        endcase
        rearm();
      end else begin
        case (ph)
          PH_HEADER: begin
            case (hdr_count)
              HDR_ID_LEN: id_left = b;
              HDR_CMAP:   cmap_type = b;
              HDR_TYPE:   img_type = b;
              HDR_W_LO:   width[7:0] = b;
              HDR_W_HI:   width[15:8] = b;
              HDR_H_LO:   height[7:0] = b;
              HDR_H_HI:   height[15:8] = b;
              HDR_DEPTH: begin
                depth32 = (b == DEPTH_32);
                depth_ok = (b == DEPTH_24) || (b == DEPTH_32);
              end
              default: ;
            endcase
            if (hdr_count < HDR_LAST) begin
              hdr_count = hdr_count + 5'd1;
            end else begin
              hdr_count = '0;
              hit = 1'b1;
              if (img_type != TYPE_TRUECOLOUR) begin
                ph = PH_WAIT;
                r = error_result(ERR_COMPRESSED);
              end else if (cmap_type != 8'd0) begin
                ph = PH_WAIT;
                r = error_result(ERR_COLOUR_MAP);
              end else if (!depth_ok) begin
                ph = PH_WAIT;
                r = error_result(ERR_BAD_DEPTH);
              end else if (id_left != 8'd0) begin
                ph = PH_ID;
                hit = 1'b0;
              end else begin
                r = header_result();
              end
            end
          end
          PH_ID: begin
            id_left = id_left - 8'd1;
            if (id_left == 8'd0) begin
              r = header_result();
              hit = 1'b1;
            end
          end
          PH_PIXELS: begin
            if (pix_byte < 2'd3) begin
              held[pix_byte] = b;
              if (pix_byte == 2'd2 && !depth32) begin
                r = pixel_result(ALPHA_OPAQUE);
                hit = 1'b1;
              end else begin
                pix_byte = pix_byte + 2'd1;
              end
            end else begin
              r = pixel_result(b);
              hit = 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (hit) expected.push_back(r);
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(decode_result_t got);
      decode_result_t want;
      if (expected.size() == 0) begin
        $display("%0t: result expected none got kind %0d", $time, got.kind);
        mismatches++;
        return;
      end
      want = expected.pop_front();
      check_field("kind", want.kind, got.kind);
      check_field("red", want.red, got.red);
      check_field("green", want.green, got.green);
      check_field("blue", want.blue, got.blue);
      check_field("alpha", want.alpha, got.alpha);
      check_field("image_width", want.image_width, got.image_width);
      check_field("image_height", want.image_height, got.image_height);
      check_field("alpha_used", want.alpha_used, got.alpha_used);
      check_field("error_code", want.error_code, got.error_code);
      check_field("last", want.last, got.last);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   items_sent;
  int   stall_cycles;
  bit   in_idle_on;
  bit   out_idle_on;
  logic [7:0] file_bytes[$];
  decode_scoreboard sb;

  tga_in_if  in_chan();
  tga_out_if out_chan();

  tga_truecolor_stream_decoder u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_chan.ready <= !out_idle_on || ($urandom_range(99) >= IdlePct);
  end

  always @(posedge clk) begin : watch
    decode_result_t seen;
    bit moved;
    if (rst_n) begin
      moved = 1'b0;
      if (out_chan.valid && out_chan.ready) begin
        seen.kind = kind_t'(out_chan.kind);
        seen.red = out_chan.red;
        seen.green = out_chan.green;
        seen.blue = out_chan.blue;
        seen.alpha = out_chan.alpha;
        seen.image_width = out_chan.image_width;
        seen.image_height = out_chan.image_height;
        seen.alpha_used = out_chan.alpha_used;
        seen.error_code = out_chan.error_code;
        seen.last = out_chan.last;
        sb.check_result(seen);
        moved = 1'b1;
      end
      if (in_chan.valid && in_chan.ready) begin
        sb.note_request(in_chan.data_byte, in_chan.end_of_stream);
        moved = 1'b1;
      end
      stall_cycles <= moved ? 0 : stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= StallLimit);
    $display("Mismatches found");
    $finish;
  end

  task automatic send_req(input logic [7:0] b, input logic eos);
    while (in_idle_on && $urandom_range(99) < IdlePct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data_byte <= b;
    in_chan.end_of_stream <= eos;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic drain_inputs();
    in_chan.valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  function automatic void build_header(logic [7:0] id_len, logic [7:0] cmap,
                                       logic [7:0] img_type, logic [15:0] w,
                                       logic [15:0] h, logic [7:0] depth);
    file_bytes.delete();
    for (int i = 0; i <= int'(HDR_LAST); i++) file_bytes.push_back(8'($urandom));
    file_bytes[HDR_ID_LEN] = id_len;
    file_bytes[HDR_CMAP] = cmap;
    file_bytes[HDR_TYPE] = img_type;
    file_bytes[HDR_W_LO] = w[7:0];
    file_bytes[HDR_W_HI] = w[15:8];
    file_bytes[HDR_H_LO] = h[7:0];
    file_bytes[HDR_H_HI] = h[15:8];
    file_bytes[HDR_DEPTH] = depth;
    repeat (id_len) file_bytes.push_back(8'($urandom));
  endfunction

  function automatic void add_pixels(int count, bit d32, int clear_pct);
    repeat (count) begin
      repeat (3) file_bytes.push_back(8'($urandom));
      if (d32)
        file_bytes.push_back(($urandom_range(99) < clear_pct) ? 8'($urandom) : ALPHA_OPAQUE);
    end
  endfunction

  task automatic send_file(int keep);
    int n;
    n = (keep < 0 || keep > file_bytes.size()) ? file_bytes.size() : keep;
    for (int i = 0; i < n; i++) send_req(file_bytes[i], 1'b0);
    send_req(8'($urandom), 1'b1);
  endtask

  task automatic random_file();
    int pick;
    bit d32;
    logic [15:0] w;
    logic [15:0] h;
    pick = $urandom_range(99);
    d32 = 1'($urandom_range(1));
    w = 16'($urandom_range(1, 3));
    h = 16'($urandom_range(1, 2));
    if (pick < 8) begin
      if ($urandom_range(1)) begin
        w = 16'($urandom);
        h = '0;
      end else begin
        w = '0;
        h = 16'($urandom);
      end
    end
    build_header(8'($urandom_range(0, 3)), 8'd0, TYPE_TRUECOLOUR, w, h,
                 d32 ? DEPTH_32 : DEPTH_24);
    add_pixels(int'(w) * int'(h), d32, $urandom_range(1) ? 0 : 40);
    repeat ($urandom_range(0, 2)) file_bytes.push_back(8'($urandom));
    if (pick < 70) begin
      send_file(-1);
    end else if (pick < 82) begin
      send_file($urandom_range(0, file_bytes.size() - 1));
    end else begin
      case ($urandom_range(2))
        0:       file_bytes[HDR_TYPE] = 8'($urandom);
        1:       file_bytes[HDR_CMAP] = 8'($urandom_range(1, 255));
        default: file_bytes[HDR_DEPTH] = 8'($urandom);
      endcase
      send_file(-1);
    end
  endtask

  initial begin
    int start_count;
    int file_no;
    sb = new();
    items_sent = 0;
    stall_cycles = 0;
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.data_byte = '0;
    in_chan.end_of_stream = 1'b0;
    out_chan.ready = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // empty stream, then header cut short
    file_bytes.delete();
    send_file(-1);
    build_header(8'd0, 8'd0, TYPE_TRUECOLOUR, 16'd1, 16'd1, DEPTH_24);
    send_file(5);
    // compressed type with trailing bytes ignored, colour map, bad depth
    build_header(8'd0, 8'd0, 8'd10, 16'd2, 16'd2, DEPTH_24);
    repeat (4) file_bytes.push_back(8'($urandom));
    send_file(-1);
    build_header(8'd0, 8'd1, TYPE_TRUECOLOUR, 16'd1, 16'd1, DEPTH_24);
    send_file(-1);
    build_header(8'd0, 8'd0, TYPE_TRUECOLOUR, 16'd1, 16'd1, 8'd16);
    send_file(-1);
    // id field cut short
    build_header(8'd3, 8'd0, TYPE_TRUECOLOUR, 16'd1, 16'd1, DEPTH_24);
    send_file(19);
    // header on last id byte, one 24-bit pixel, bytes after done
    build_header(8'd2, 8'd0, TYPE_TRUECOLOUR, 16'd1, 16'd1, DEPTH_24);
    add_pixels(1, 1'b0, 0);
    repeat (3) file_bytes.push_back(8'($urandom));
    send_file(-1);
    // 32-bit opaque pixel then transparent one, channel extremes
    build_header(8'd0, 8'd0, TYPE_TRUECOLOUR, 16'd2, 16'd1, DEPTH_32);
    repeat (3) file_bytes.push_back(8'h00);
    file_bytes.push_back(8'hff);
    repeat (3) file_bytes.push_back(8'hff);
    file_bytes.push_back(8'h00);
    send_file(-1);
    // zero-size images
    build_header(8'd0, 8'd0, TYPE_TRUECOLOUR, 16'hffff, 16'd0, DEPTH_32);
    send_file(-1);
    build_header(8'hff, 8'd0, TYPE_TRUECOLOUR, 16'd0, 16'hffff, DEPTH_24);
    send_file(-1);
    // pixels cut short
    build_header(8'd0, 8'd0, TYPE_TRUECOLOUR, 16'd2, 16'd2, DEPTH_32);
    add_pixels(4, 1'b1, 50);
    send_file(24);
    drain_inputs();

    start_count = items_sent;
    file_no = 0;
    while (items_sent - start_count < RandomItems) begin
      in_idle_on = !(file_no >= 1 && file_no < 4);
      out_idle_on = in_idle_on;
      if (file_no == 4) drain_inputs();
      random_file();
      file_no++;
    end
    in_chan.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
